/* rtl/unaligned_bit_pattern_finder_macros.svh */
// assertion macros shared by the rtl files
`ifndef UNALIGNED_BIT_PATTERN_FINDER_MACROS_SVH
`define UNALIGNED_BIT_PATTERN_FINDER_MACROS_SVH

`ifndef SYNTH
`define UBPF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define UBPF_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define UBPF_ASSERT(lbl, clk, rst_n, prop, msg)
`define UBPF_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

/* rtl/ubpf_pkg.sv */
`timescale 1ns / 1ps

package ubpf_pkg;

  localparam int OffsetBits     = 40;
  localparam int CountBits      = OffsetBits - 3;
  localparam int MaxPatternBits = 56;
  localparam int CfgDataBits    = 56;
  localparam int CfgIndexBits   = 2;
  localparam int LenBits        = 6;
  localparam int IgnoreBits     = 8;
  localparam int Alignments     = 8;
  localparam int QueueDepth     = 4;
  localparam int QueuePtrBits   = $clog2(QueueDepth);

  localparam logic [CfgDataBits-1:0] PatternReset = 56'h0000_3141_5926_5359;
  localparam logic [LenBits-1:0]     LengthReset  = 6'd48;
  localparam logic [IgnoreBits-1:0]  IgnoreReset  = 8'd0;

  typedef enum logic [CfgIndexBits-1:0] {
    CfgPattern = 2'd0,
    CfgLength  = 2'd1,
    CfgIgnore  = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [OffsetBits-1:0] bit_offset;
    logic                  last_of_run;
  } out_item_t;

  // one byte's qualified matches, bit s set for alignment shift s
  typedef struct packed {
    logic [Alignments-1:0] hits;
    logic [OffsetBits-1:0] rel;
  } entry_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } q_stat_t;

endpackage

/* rtl/unaligned_bit_pattern_finder.sv */
`timescale 1ns / 1ps
// channel | direction | handshake               | payload
// in      | input     | in_valid_i / in_stall_o | in_data_i (data_byte, last_byte)
// out     | output    | out_valid_o / out_stall_i | out_data_o (bit_offset, last_of_run)
// cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// one byte accepted per cycle unless the 4-entry queue is full; matches enter it that cycle
// the back end emits one match per cycle unless stalled; a byte's matches leave in turn
// a byte's matches pass through the queue and then the output register; bytes without a match never enter the queue
// in_stall_o rises only while the queue is full; out_stall_i holds the output register
// asynchronous reset clears window, byte count, queue and output valid; no clearing pass

module unaligned_bit_pattern_finder #(
  parameter int MAX_PATTERN_BITS = ubpf_pkg::MaxPatternBits
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [ubpf_pkg::CfgIndexBits-1:0] cfg_index_i,
  input  logic [ubpf_pkg::CfgDataBits-1:0]  cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  ubpf_pkg::in_item_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output ubpf_pkg::out_item_t               out_data_o
);

  logic              accept;
  logic              push;
  logic              pop;
  ubpf_pkg::entry_t  entry;
  ubpf_pkg::entry_t  head;
  ubpf_pkg::q_stat_t q_stat;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_stat.full;
  assign accept      = in_valid_i && !q_stat.full;

  ubpf_front #(
    .MAX_PATTERN_BITS(MAX_PATTERN_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .item_i     (in_data_i),
    .push_o     (push),
    .entry_o    (entry)
  );

  ubpf_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .entry_i(entry),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (q_stat)
  );

  ubpf_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (head),
    .stat_i     (q_stat),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule

/* rtl/ubpf_front.sv */
`timescale 1ns / 1ps

module ubpf_front #(
  parameter int MAX_PATTERN_BITS = ubpf_pkg::MaxPatternBits
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic [ubpf_pkg::CfgIndexBits-1:0]   cfg_index_i,
  input  logic [ubpf_pkg::CfgDataBits-1:0]    cfg_data_i,
  input  logic                                accept_i,
  input  ubpf_pkg::in_item_t                  item_i,
  output logic                                push_o,
  output ubpf_pkg::entry_t                    entry_o
);

  localparam int WinBits = MAX_PATTERN_BITS + 7;
  localparam int W       = ubpf_pkg::OffsetBits;
  localparam int KBits   = 10;

  logic [MAX_PATTERN_BITS-1:0]     pattern_q;
  logic [ubpf_pkg::LenBits-1:0]    len_q;
  logic [ubpf_pkg::IgnoreBits-1:0] ignore_q;
  logic [WinBits-1:0]              win_q, win_d, win_new;
  logic [ubpf_pkg::CountBits-1:0]  count_q, count_d;
  logic [ubpf_pkg::LenBits-1:0]    len_eff;
  logic [MAX_PATTERN_BITS-1:0]     lmask;
  logic [W:0]                      base;
  logic [ubpf_pkg::Alignments-1:0] hits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= MAX_PATTERN_BITS'(ubpf_pkg::PatternReset);
      len_q     <= ubpf_pkg::LengthReset;
      ignore_q  <= ubpf_pkg::IgnoreReset;
    end else if (cfg_valid_i) begin
      unique case (ubpf_pkg::cfg_reg_e'(cfg_index_i))
        ubpf_pkg::CfgPattern: pattern_q <= cfg_data_i[MAX_PATTERN_BITS-1:0];
        ubpf_pkg::CfgLength:  len_q     <= cfg_data_i[ubpf_pkg::LenBits-1:0];
        ubpf_pkg::CfgIgnore:  ignore_q  <= cfg_data_i[ubpf_pkg::IgnoreBits-1:0];
        default: ;
      endcase
    end
  end

  // lengths above the window limit behave as the limit
  assign len_eff = (len_q > ubpf_pkg::LenBits'(MAX_PATTERN_BITS)) ?
                   ubpf_pkg::LenBits'(MAX_PATTERN_BITS) : len_q;

  always_comb begin
    for (int i = 0; i < MAX_PATTERN_BITS; i++) begin
      lmask[i] = (i < int'(len_eff));
    end
  end

  assign win_new = {win_q[WinBits-9:0], item_i.data_byte};
  // bit count up to and including this byte
  assign base    = {1'b0, count_q, 3'b000} + (W+1)'(8);

  always_comb begin
    logic [KBits-1:0] k;
    for (int s = 0; s < ubpf_pkg::Alignments; s++) begin
      k = KBits'(len_eff) + KBits'(s) + KBits'(ignore_q);
      hits[s] = (len_eff != '0) &&
                (((win_new[s +: MAX_PATTERN_BITS] ^ pattern_q) & lmask) == '0) &&
                (base >= (W+1)'(k));
    end
  end

  assign entry_o.hits = hits;
  assign entry_o.rel  = W'(base - (W+1)'(KBits'(len_eff) + KBits'(ignore_q)));
  assign push_o       = accept_i && (hits != '0);

  always_comb begin
    win_d   = win_q;
    count_d = count_q;
    if (accept_i) begin
      if (item_i.last_byte) begin
        win_d   = '0;
        count_d = '0;
      end else begin
        win_d   = win_new;
        count_d = count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= '0;
      count_q <= '0;
    end else begin
      win_q   <= win_d;
      count_q <= count_d;
    end
  end

endmodule

/* rtl/ubpf_fifo.sv */
`timescale 1ns / 1ps
`include "unaligned_bit_pattern_finder_macros.svh"

module ubpf_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ubpf_pkg::entry_t  entry_i,
  input  logic              pop_i,
  output ubpf_pkg::entry_t  head_o,
  output ubpf_pkg::q_stat_t stat_o
);

  ubpf_pkg::entry_t                  mem_q [ubpf_pkg::QueueDepth];
  logic [ubpf_pkg::QueuePtrBits-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [ubpf_pkg::QueuePtrBits:0]   fill_q, fill_d;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  assign head_o           = mem_q[rd_q];
  assign stat_o.not_empty = (fill_q != '0);
  assign stat_o.full      = (fill_q == (ubpf_pkg::QueuePtrBits+1)'(ubpf_pkg::QueueDepth));

  always_comb begin
    wr_d   = push_i ? wr_q + 1'b1 : wr_q;
    rd_d   = pop_i ? rd_q + 1'b1 : rd_q;
    fill_d = fill_q;
    if (push_i && !pop_i) begin
      fill_d = fill_q + 1'b1;
    end else if (pop_i && !push_i) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

  `UBPF_ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && stat_o.full, "queue overflow")
  `UBPF_ASSERT_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && !stat_o.not_empty, "queue underflow")

endmodule

/* rtl/ubpf_back.sv */
`timescale 1ns / 1ps
`include "unaligned_bit_pattern_finder_macros.svh"

module ubpf_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ubpf_pkg::entry_t    head_i,
  input  ubpf_pkg::q_stat_t   stat_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output ubpf_pkg::out_item_t out_data_o
);

  logic [ubpf_pkg::Alignments-1:0] done_q, done_d;
  logic [ubpf_pkg::Alignments-1:0] rem, rem_after, pick;
  logic [2:0]                      sel;
  logic                            load;
  logic                            out_vld_q, out_vld_d;
  ubpf_pkg::out_item_t             out_q, out_d;

  assign rem = head_i.hits & ~done_q;

  // largest shift first: earliest start bit
  always_comb begin
    sel = '0;
    for (int i = 0; i < ubpf_pkg::Alignments; i++) begin
      if (rem[i]) begin
        sel = 3'(i);
      end
    end
  end

  assign pick      = ubpf_pkg::Alignments'(1) << sel;
  assign rem_after = rem & ~pick;
  assign load      = stat_i.not_empty && (!out_vld_q || !out_stall_i);
  assign pop_o     = load && (rem_after == '0);

  always_comb begin
    done_d    = done_q;
    out_vld_d = out_vld_q;
    out_d     = out_q;
    if (!out_vld_q || !out_stall_i) begin
      out_vld_d = stat_i.not_empty;
    end
    if (load) begin
      out_d.bit_offset  = head_i.rel - ubpf_pkg::OffsetBits'(sel);
      out_d.last_of_run = (rem_after == '0);
      done_d            = (rem_after == '0) ? '0 : (done_q | pick);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      done_q    <= done_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  `UBPF_ASSERT(a_head_has_work, clk_i, rst_ni, stat_i.not_empty |-> (rem != '0), "queued entry without pending match")
  `UBPF_ASSERT_NEVER(a_done_in_hits, clk_i, rst_ni, stat_i.not_empty && ((done_q & ~head_i.hits) != '0), "done mask outside head hits")
  `UBPF_ASSERT(a_run_continues, clk_i, rst_ni, (out_vld_q && !out_stall_i && !out_q.last_of_run) |=> out_vld_q, "run broken before last match")

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

  typedef enum logic {RowByte, RowCfg} row_kind_e;

  typedef struct packed {
    row_kind_e                        kind;
    ubpf_pkg::cfg_reg_e               idx;
    logic [ubpf_pkg::CfgDataBits-1:0] value;
    ubpf_pkg::in_item_t               item;
    logic                             fixed;
    logic [3:0]                       nfix;
    logic [ubpf_pkg::OffsetBits-1:0]  fix_off;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  logic                             cfg_valid;
  logic                             cfg_ready;
  ubpf_pkg::cfg_reg_e               cfg_index;
  logic [ubpf_pkg::CfgDataBits-1:0] cfg_data;
  logic                             in_valid;
  logic                             in_stall;
  ubpf_pkg::in_item_t               in_data;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  ubpf_pkg::out_item_t              out_data;

  // shadow of the block: window, byte position and registers
  logic [63:0]                       shift_bits = '0;
  logic [ubpf_pkg::CountBits-1:0]    bytes_seen = '0;
  logic [ubpf_pkg::CfgDataBits-1:0]  pat_cfg    = ubpf_pkg::PatternReset;
  logic [ubpf_pkg::LenBits-1:0]      len_cfg    = ubpf_pkg::LengthReset;
  logic [ubpf_pkg::IgnoreBits-1:0]   skip_cfg   = ubpf_pkg::IgnoreReset;

  ubpf_pkg::out_item_t found [8];
  int                  found_n;
  ubpf_pkg::out_item_t match_q [$];
  dir_row_t            dir_q [$];
  int                  errors = 0;
  int                  burst_left = 0;
  int                  stall_mode = 0;
  int                  mode_left = 0;

  unaligned_bit_pattern_finder u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic void add_match(input ubpf_pkg::out_item_t m);
    match_q.insert(match_q.size(), m);
  endfunction

  function automatic void add_row(input dir_row_t r);
    dir_q.insert(dir_q.size(), r);
  endfunction

  // compare the eight alignments that end in this byte, then advance the shadow state
  task automatic find_matches(input ubpf_pkg::in_item_t it);
    logic [63:0] pos_bits;
    logic [63:0] lmask;
    logic [63:0] want;
    logic [63:0] start;
    logic [63:0] need;
    logic [63:0] diff;
    int          len;
    int          s;
    bit          tested;
    found_n = 0;
    shift_bits = {shift_bits[55:0], it.data_byte};
    pos_bits = {{(64 - ubpf_pkg::CountBits){1'b0}}, bytes_seen} << 3;
    len = (len_cfg > ubpf_pkg::MaxPatternBits) ? ubpf_pkg::MaxPatternBits : int'(len_cfg);
    if (len > 0) begin
      lmask = (64'd1 << len) - 64'd1;
      want = {8'd0, pat_cfg} & lmask;
      // earliest start first
      for (s = 7; s >= 0; s--) begin
        need = len + s;
        tested = 1'b1;
        if (need <= 8) begin
          start = pos_bits + 8 - need;
        end else if (pos_bits >= need - 8) begin
          start = pos_bits - (need - 8);
        end else begin
          tested = 1'b0;
        end
        if (tested && (((shift_bits >> s) & lmask) == want) && (start >= skip_cfg)) begin
          diff = start - skip_cfg;
          found[found_n].bit_offset = diff[ubpf_pkg::OffsetBits-1:0];
          found[found_n].last_of_run = 1'b0;
          found_n++;
        end
      end
      if (found_n > 0) found[found_n-1].last_of_run = 1'b1;
    end
    if (it.last_byte) begin
      shift_bits = '0;
      bytes_seen = '0;
    end else begin
      bytes_seen = bytes_seen + 1'b1;
    end
  endtask

  task automatic send_byte(input ubpf_pkg::in_item_t it, input bit fixed, input int nfix,
                           input logic [ubpf_pkg::OffsetBits-1:0] off);
    int                  k;
    int                  gap;
    ubpf_pkg::out_item_t e;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end else begin
      burst_left--;
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data = it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    find_matches(it);
    if (fixed) begin
      for (k = 0; k < nfix; k++) begin
        e.bit_offset = off;
        e.last_of_run = 1'b1;
        add_match(e);
      end
    end else begin
      for (k = 0; k < found_n; k++) add_match(found[k]);
    end
  endtask

  // drop valid and let every pending match come out before touching registers
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (match_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input ubpf_pkg::cfg_reg_e idx,
                           input logic [ubpf_pkg::CfgDataBits-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      ubpf_pkg::CfgPattern: pat_cfg = val;
      ubpf_pkg::CfgLength:  len_cfg = val[ubpf_pkg::LenBits-1:0];
      ubpf_pkg::CfgIgnore:  skip_cfg = val[ubpf_pkg::IgnoreBits-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic dir_row_t byte_row(input logic [7:0] d, input logic l, input bit fx,
                                        input int nf,
                                        input logic [ubpf_pkg::OffsetBits-1:0] off);
    dir_row_t r;
    r = '0;
    r.kind = RowByte;
    r.idx = ubpf_pkg::CfgPattern;
    r.item.data_byte = d;
    r.item.last_byte = l;
    r.fixed = fx;
    r.nfix = nf[3:0];
    r.fix_off = off;
    return r;
  endfunction

  function automatic dir_row_t cfg_row(input ubpf_pkg::cfg_reg_e idx,
                                       input logic [ubpf_pkg::CfgDataBits-1:0] v);
    dir_row_t r;
    r = '0;
    r.kind = RowCfg;
    r.idx = idx;
    r.value = v;
    return r;
  endfunction

  // receiver: switches between free running, light and heavy stalling
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall = 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        mode_left = $urandom_range(10, 60);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: out_stall = 1'b0;
        1: out_stall = ($urandom_range(0, 9) < 4);
        default: out_stall = ($urandom_range(0, 9) < 7);
      endcase
    end
  end

  always @(posedge clk) begin
    ubpf_pkg::out_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (match_q.size() == 0) begin
        $display("%0t: unexpected match transaction, actual offset %0d last %0b",
                 $time, out_data.bit_offset, out_data.last_of_run);
        errors++;
      end else begin
        e = match_q.pop_front();
        if (out_data.bit_offset !== e.bit_offset) begin
          $display("%0t: bit_offset mismatch, expected %0d actual %0d",
                   $time, e.bit_offset, out_data.bit_offset);
          errors++;
        end
        if (out_data.last_of_run !== e.last_of_run) begin
          $display("%0t: last_of_run mismatch, expected %0b actual %0b",
                   $time, e.last_of_run, out_data.last_of_run);
          errors++;
        end
      end
    end
  end

  initial begin
    dir_row_t                         row;
    ubpf_pkg::in_item_t               it;
    bit                               bq [$];
    int                               sent;
    int                               i;
    int                               b;
    int                               c;
    int                               sel;
    int                               len;
    int                               eff;
    int                               emb;
    int                               nbits;
    int                               copies;
    int                               flip;
    int                               kind;
    int                               nbuf;
    int                               nbytes;
    logic [7:0]                       ign;
    logic [63:0]                      rnd;
    logic [ubpf_pkg::CfgDataBits-1:0] pat;
    logic [ubpf_pkg::CfgDataBits-1:0] junk;

    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = ubpf_pkg::CfgPattern;
    cfg_data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset pattern: first byte is too short to hold it, then a full copy at offset 0
    add_row(byte_row(8'h31, 1'b0, 1, 0, '0));
    add_row(byte_row(8'h41, 1'b0, 0, 0, '0));
    add_row(byte_row(8'h59, 1'b0, 0, 0, '0));
    add_row(byte_row(8'h26, 1'b0, 0, 0, '0));
    add_row(byte_row(8'h53, 1'b0, 0, 0, '0));
    add_row(byte_row(8'h59, 1'b1, 0, 0, '0));
    // junk above the length and above the pattern bits must be ignored
    add_row(cfg_row(ubpf_pkg::CfgPattern, 56'hFF_FFFF_FFFF_FFA5));
    add_row(cfg_row(ubpf_pkg::CfgLength, 56'hFF_FFFF_FFFF_FFC8));
    add_row(byte_row(8'hA5, 1'b1, 1, 1, '0));
    // single bit pattern: eight hits in one byte
    add_row(cfg_row(ubpf_pkg::CfgLength, 56'd1));
    add_row(cfg_row(ubpf_pkg::CfgPattern, 56'd1));
    add_row(byte_row(8'hFF, 1'b0, 0, 0, '0));
    add_row(byte_row(8'h00, 1'b0, 1, 0, '0));
    add_row(byte_row(8'h80, 1'b1, 0, 0, '0));
    // zero length never hits
    add_row(cfg_row(ubpf_pkg::CfgLength, 56'd0));
    add_row(byte_row(8'hFF, 1'b0, 1, 0, '0));
    add_row(byte_row(8'hA5, 1'b1, 1, 0, '0));
    // overlong length clamps to the maximum, with some leading hits skipped
    add_row(cfg_row(ubpf_pkg::CfgPattern, {ubpf_pkg::CfgDataBits{1'b1}}));
    add_row(cfg_row(ubpf_pkg::CfgLength, 56'd63));
    add_row(cfg_row(ubpf_pkg::CfgIgnore, 56'd5));
    for (i = 0; i < 8; i++) add_row(byte_row(8'hFF, i == 7, 0, 0, '0));
    add_row(cfg_row(ubpf_pkg::CfgPattern, 56'd0));
    add_row(cfg_row(ubpf_pkg::CfgLength, 56'd8));
    add_row(cfg_row(ubpf_pkg::CfgIgnore, 56'd0));
    add_row(byte_row(8'h00, 1'b0, 1, 1, '0));
    add_row(byte_row(8'h00, 1'b1, 0, 0, '0));

    foreach (dir_q[ri]) begin
      row = dir_q[ri];
      if (row.kind == RowCfg) begin
        drain();
        write_reg(row.idx, row.value);
      end else begin
        send_byte(row.item, row.fixed, int'(row.nfix), row.fix_off);
      end
    end

    sent = 0;
    while (sent < 380) begin
      drain();
      sel = $urandom_range(0, 9);
      case (sel)
        0:       len = 0;
        1:       len = $urandom_range(57, 63);
        2:       len = ubpf_pkg::MaxPatternBits;
        3:       len = 1;
        4, 5:    len = $urandom_range(25, 55);
        default: len = $urandom_range(2, 24);
      endcase
      sel = $urandom_range(0, 9);
      rnd = {$urandom, $urandom};
      if (sel == 0) pat = '0;
      else if (sel == 1) pat = '1;
      else pat = rnd[ubpf_pkg::CfgDataBits-1:0];
      sel = $urandom_range(0, 9);
      if (sel < 4) ign = 8'd0;
      else if (sel < 6) ign = 8'd255;
      else ign = 8'($urandom_range(0, 255));
      write_reg(ubpf_pkg::CfgPattern, pat);
      rnd = {$urandom, $urandom};
      junk = rnd[ubpf_pkg::CfgDataBits-1:0];
      write_reg(ubpf_pkg::CfgLength,
                {junk[ubpf_pkg::CfgDataBits-1:ubpf_pkg::LenBits], len[ubpf_pkg::LenBits-1:0]});
      rnd = {$urandom, $urandom};
      junk = rnd[ubpf_pkg::CfgDataBits-1:0];
      write_reg(ubpf_pkg::CfgIgnore, {junk[ubpf_pkg::CfgDataBits-1:ubpf_pkg::IgnoreBits], ign});

      eff = (len > ubpf_pkg::MaxPatternBits) ? ubpf_pkg::MaxPatternBits : len;
      emb = (eff == 0) ? 8 : eff;
      nbuf = $urandom_range(1, 3);
      for (c = 0; c < nbuf; c++) begin
        bq.delete();
        nbits = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 40);
        repeat (nbits) bq.insert(bq.size(), 1'($urandom_range(0, 1)));
        kind = $urandom_range(0, 9);
        if (kind == 7 || kind == 8) begin
          // plain noise
          nbits = $urandom_range(8, 64);
          repeat (nbits) bq.insert(bq.size(), 1'($urandom_range(0, 1)));
        end else begin
          copies = $urandom_range(1, 2);
          repeat (copies) begin
            // a broken copy has one bit flipped
            flip = (kind == 9) ? $urandom_range(0, emb - 1) : -1;
            for (b = emb - 1; b >= 0; b--) bq.insert(bq.size(), pat[b] ^ (b == flip));
            nbits = $urandom_range(0, 12);
            repeat (nbits) bq.insert(bq.size(), 1'($urandom_range(0, 1)));
          end
        end
        nbits = $urandom_range(0, 16);
        repeat (nbits) bq.insert(bq.size(), 1'($urandom_range(0, 1)));
        while (bq.size() % 8 != 0) bq.insert(bq.size(), 1'($urandom_range(0, 1)));
        nbytes = bq.size() / 8;
        for (i = 0; i < nbytes; i++) begin
          for (b = 0; b < 8; b++) it.data_byte[7-b] = bq[i*8 + b];
          it.last_byte = (i == nbytes - 1) || ($urandom_range(0, 40) == 0);
          send_byte(it, 0, 0, '0);
          sent++;
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* unaligned_bit_pattern_finder.f */
+incdir+rtl
rtl/ubpf_pkg.sv
rtl/ubpf_front.sv
rtl/ubpf_fifo.sv
rtl/ubpf_back.sv
rtl/unaligned_bit_pattern_finder.sv
dv/tb_top.sv
